/* rtl/ais_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ais_pkg
// Shared types and codes for the ascending integer sorter.
// ----------------------------------------------------------------------------
package ais_pkg;

    localparam int WORD_W = 32;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic                     last;
    } ais_in_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] value_res;
        logic                     last_res;
        logic                     overflow;
    } ais_out_t;

    // request passed from the front to the back
    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic                     keep;
        logic                     last;
        logic                     overflow;
    } ais_req_t;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } ais_state_t;

endpackage
`default_nettype wire

/* rtl/ais_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ais_front
// Accepts input items, counts the run and marks each request as kept or
// dropped, with the run's overflow state on the closing request.
// ----------------------------------------------------------------------------
module ais_front
    import ais_pkg::*;
#(
    parameter int MAX_ITEMS = 32
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire ais_in_t  s_data,
    output logic          req_valid,
    input  wire logic     req_ready,
    output ais_req_t      req_data
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             drop_reg, drop_next;
    logic             keep;
    logic             accept;

    assign s_ready   = req_ready;
    assign req_valid = s_valid;
    assign accept    = s_valid && req_ready;
    assign keep      = (count_reg < CNT_W'(MAX_ITEMS));

    always_comb begin
        req_data.value    = s_data.value;
        req_data.last     = s_data.last;
        req_data.keep     = keep;
        req_data.overflow = drop_reg || !keep;
    end

    always_comb begin
        count_next = count_reg;
        drop_next  = drop_reg;
        if (accept) begin
            if (s_data.last) begin
                count_next = '0;
                drop_next  = 1'b0;
            end else if (keep) begin
                count_next = count_reg + CNT_W'(1);
            end else begin
                drop_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            drop_reg  <= drop_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/ais_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ais_queue
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module ais_queue
    import ais_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     wr_valid,
    output logic          wr_ready,
    input  wire ais_req_t wr_data,
    output logic          rd_valid,
    input  wire logic     rd_ready,
    output ais_req_t      rd_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    ais_req_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              push, pop;

    assign wr_ready = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + FILL_W'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/ais_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ais_back
// Insertion cell array that keeps the run in ascending order, then shifts
// it out through the output register once the run closes.
// ----------------------------------------------------------------------------
module ais_back
    import ais_pkg::*;
#(
    parameter int MAX_ITEMS = 32
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire ais_req_t req_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output ais_out_t      m_data
);

    ais_state_t               state_reg, state_next;
    logic signed [WORD_W-1:0] cell_reg [MAX_ITEMS];
    logic signed [WORD_W-1:0] cell_next [MAX_ITEMS];
    logic [MAX_ITEMS-1:0]     valid_reg, valid_next;
    logic [MAX_ITEMS-1:0]     lt;
    logic                     ovf_reg, ovf_next;
    logic                     m_valid_reg, m_valid_next;
    ais_out_t                 out_reg, out_next;
    logic                     pop, insert, emit;

    assign req_ready = (state_reg == ST_LOAD);
    assign pop       = req_valid && req_ready;
    assign insert    = pop && req_data.keep;
    assign emit      = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    // new value goes before every cell that is empty or holds a larger value
    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            lt[i] = !valid_reg[i] || ($signed(req_data.value) < $signed(cell_reg[i]));
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            cell_next[i] = cell_reg[i];
        end
        valid_next = valid_reg;
        if (insert) begin
            for (int i = 0; i < MAX_ITEMS; i++) begin
                if (lt[i]) begin
                    if (i == 0) begin
                        cell_next[i] = req_data.value;
                    end else if (!lt[i-1]) begin
                        cell_next[i] = req_data.value;
                    end else begin
                        cell_next[i] = cell_reg[i-1];
                    end
                end
            end
            valid_next = {valid_reg[MAX_ITEMS-2:0], 1'b1};
        end else if (emit) begin
            for (int i = 0; i < MAX_ITEMS - 1; i++) begin
                cell_next[i] = cell_reg[i+1];
            end
            valid_next = {1'b0, valid_reg[MAX_ITEMS-1:1]};
        end
    end

    always_comb begin
        state_next   = state_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_LOAD: begin
                if (pop && req_data.last) begin
                    ovf_next   = req_data.overflow;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit) begin
                    m_valid_next       = 1'b1;
                    out_next.value_res = cell_reg[0];
                    out_next.last_res  = !valid_reg[1];
                    out_next.overflow  = ovf_reg;
                    if (!valid_reg[1]) begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            cell_reg[i] <= cell_next[i];
        end
        out_reg <= out_next;
        ovf_reg <= ovf_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTH
    // occupied cells always form one block starting at cell zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot({1'b0, valid_reg} + (MAX_ITEMS + 1)'(1)))
        else $error("cell occupancy not contiguous");

    // the array is never empty while the run is being shifted out
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> valid_reg[0])
        else $error("emitting from an empty array");

    // a kept value always finds a free cell
    assert property (@(posedge aclk) disable iff (!aresetn)
        insert |-> !valid_reg[MAX_ITEMS-1])
        else $error("insert into a full array");

    // a closing request always leaves something to emit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && req_data.last) |=> valid_reg[0])
        else $error("run closed with no stored value");
`endif

endmodule
`default_nettype wire

/* rtl/ascending_integer_sorter.sv */
// Output: m_valid for a closing item's first result rises after the queue slot, the back's
// move to ST_EMIT and the output register. Throughput: one input per cycle while loading;
// a run of n values then streams out one result per cycle while m_ready is high, set by the
// shift of the cell array. The two phases share the cell array and do not overlap.
// Reset: synchronous, active low on aresetn; clears run count, queue and array
// occupancy. Value registers are not reset.
`default_nettype none
// ----------------------------------------------------------------------------
// ascending_integer_sorter
// Collects a run of signed values and returns them in ascending order.
// ----------------------------------------------------------------------------
module ascending_integer_sorter
    import ais_pkg::*;
#(
    parameter int MAX_ITEMS = 32
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire ais_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output ais_out_t      m_data
);

    logic     fq_valid, fq_ready;
    ais_req_t fq_data;
    logic     qb_valid, qb_ready;
    ais_req_t qb_data;

    ais_front #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .req_valid (fq_valid),
        .req_ready (fq_ready),
        .req_data  (fq_data)
    );

    ais_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    ais_back #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (qb_valid),
        .req_ready (qb_ready),
        .req_data  (qb_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire
